[sv/lat_pkg.sv]
package lat_pkg;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } lat_op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] col;
    logic [5:0] row;
    logic       alive_in;
  } lat_in_t;

  typedef struct packed {
    logic       cell_alive;
    logic [1:0] ack_kind;
  } lat_out_t;

endpackage

[sv/life_automaton_torus.sv]
// Life automaton on a torus, rule B3/S23.
//
// Commands enter on cmd and are taken at a clock edge where start is high and
// busy is low. Each command gives one result beat on result, marked by done
// for exactly one cycle; the receiver must take it then.
// A cell write or read registers its beat in the cell state that follows acceptance.
// An advance loads the last row and rows zero and one, then computes each row in order: the grid
// memory holds one row per word, three rows sit in rotating registers, and a
// single rule unit produces one new cell per cycle while a row is computed.
// Each finished row is written back in its own write state. Row zero is
// kept in a register so that the last row still sees its old neighbors. Busy
// stays high throughout a command, so one command is in flight at a time.
// After reset the block sweeps the grid to all dead, one row per cycle, with
// busy high until every row is cleared. Coordinates outside the grid make a
// write do nothing and a read return dead. The unused op code only echoes.
module life_automaton_torus #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  lat_pkg::lat_in_t   cmd,
  output logic               busy,
  output logic               done,
  output lat_pkg::lat_out_t  result
);

  import lat_pkg::*;

  localparam int XW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);

  typedef enum logic [5:0] {
    S_CLEAR   = 6'b000001,
    S_IDLE    = 6'b000010,
    S_CELL    = 6'b000100,
    S_LOAD    = 6'b001000,
    S_COMPUTE = 6'b010000,
    S_WRITE   = 6'b100000
  } state_t;

  state_t                state;
  lat_in_t               cur_cmd;
  logic                  cur_inside;
  logic [XW-1:0]         col_cnt;
  logic [RW-1:0]         row_cnt;
  logic [1:0]            ld_cnt;
  logic [GRID_WIDTH-1:0] prev_row;
  logic [GRID_WIDTH-1:0] cur_row;
  logic [GRID_WIDTH-1:0] next_row;
  logic [GRID_WIDTH-1:0] first_row;
  logic [GRID_WIDTH-1:0] new_row;

  logic                  in_inside;
  logic [XW-1:0]         col_idx;
  logic [GRID_WIDTH-1:0] patched_row;
  logic                  cell_next;

  logic                  mem_we;
  logic [RW-1:0]         mem_waddr;
  logic [GRID_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [RW-1:0]         mem_raddr;
  logic [GRID_WIDTH-1:0] mem_rdata;

  assign busy      = (state != S_IDLE);
  assign in_inside = (32'(cmd.col) < GRID_WIDTH) && (32'(cmd.row) < GRID_HEIGHT);
  assign col_idx   = XW'(cur_cmd.col);

  always_comb begin
    patched_row          = mem_rdata;
    patched_row[col_idx] = cur_cmd.alive_in;
  end

  lat_rule u_rule (
    .above  ({prev_row[1], prev_row[0], prev_row[GRID_WIDTH-1]}),
    .middle ({cur_row[1],  cur_row[0],  cur_row[GRID_WIDTH-1]}),
    .below  ({next_row[1], next_row[0], next_row[GRID_WIDTH-1]}),
    .alive  (cell_next)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_cnt;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = row_cnt;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_re    = start && in_inside;
        mem_raddr = RW'(cmd.row);
      end
      S_CELL: begin
        mem_we    = cur_inside && (cur_cmd.op == OP_WRITE);
        mem_waddr = RW'(cur_cmd.row);
        mem_wdata = patched_row;
      end
      S_LOAD: begin
        mem_re = (ld_cnt != 2'd3);
        case (ld_cnt)
          2'd0:    mem_raddr = RW'(GRID_HEIGHT - 1);
          2'd1:    mem_raddr = '0;
          default: mem_raddr = RW'(1);
        endcase
      end
      S_COMPUTE: begin
        mem_re    = (col_cnt == '0) && (32'(row_cnt) < GRID_HEIGHT - 2);
        mem_raddr = RW'(32'(row_cnt) + 2);
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = new_row;
      end
      default: begin
      end
    endcase
  end

  lat_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      row_cnt <= '0;
      col_cnt <= '0;
      ld_cnt  <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (row_cnt == RW'(GRID_HEIGHT - 1)) begin
            row_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            row_cnt <= row_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur_cmd    <= cmd;
            cur_inside <= in_inside;
            ld_cnt     <= '0;
            if (cmd.op == OP_ADVANCE) begin
              state <= S_LOAD;
            end else begin
              state <= S_CELL;
            end
          end
        end
        S_CELL: begin
          done              <= 1'b1;
          result.ack_kind   <= cur_cmd.op;
          result.cell_alive <= (cur_cmd.op == OP_READ) && cur_inside && mem_rdata[col_idx];
          state             <= S_IDLE;
        end
        S_LOAD: begin
          if (ld_cnt != 2'd0) begin
            prev_row <= cur_row;
            cur_row  <= next_row;
            next_row <= mem_rdata;
          end
          if (ld_cnt == 2'd3) begin
            first_row <= next_row;
            col_cnt   <= '0;
            row_cnt   <= '0;
            state     <= S_COMPUTE;
          end else begin
            ld_cnt <= ld_cnt + 1'b1;
          end
        end
        S_COMPUTE: begin
          prev_row <= {prev_row[0], prev_row[GRID_WIDTH-1:1]};
          cur_row  <= {cur_row[0],  cur_row[GRID_WIDTH-1:1]};
          next_row <= {next_row[0], next_row[GRID_WIDTH-1:1]};
          new_row  <= {cell_next,   new_row[GRID_WIDTH-1:1]};
          if (col_cnt == XW'(GRID_WIDTH - 1)) begin
            col_cnt <= '0;
            state   <= S_WRITE;
          end else begin
            col_cnt <= col_cnt + 1'b1;
          end
        end
        S_WRITE: begin
          prev_row <= cur_row;
          cur_row  <= next_row;
          if (32'(row_cnt) == GRID_HEIGHT - 2) begin
            next_row <= first_row;
          end else begin
            next_row <= mem_rdata;
          end
          if (row_cnt == RW'(GRID_HEIGHT - 1)) begin
            done              <= 1'b1;
            result.ack_kind   <= OP_ADVANCE;
            result.cell_alive <= 1'b0;
            row_cnt           <= '0;
            state             <= S_IDLE;
          end else begin
            row_cnt <= row_cnt + 1'b1;
            state   <= S_COMPUTE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

[sv/lat_ram.sv]
module lat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/lat_rule.sv]
module lat_rule (
  input  logic [2:0] above,
  input  logic [2:0] middle,
  input  logic [2:0] below,
  output logic       alive
);

  import lat_pkg::*;

  localparam logic [3:0] BornCount = 4'd3;
  localparam logic [3:0] KeepCount = 4'd2;

  logic [3:0] count;

  // The centre tap is the cell itself and is not a neighbor.
  assign count = 4'($countones({above, middle[2], middle[0], below}));
  assign alive = (count == BornCount) || (middle[1] && (count == KeepCount));

endmodule

[sv/lat_check.sv]
module lat_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input lat_pkg::lat_out_t result
);

  import lat_pkg::*;

  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy && !done)
    else $error("block not clearing after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not make the block busy");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beats back to back");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  a_alive_only_read: assert property (@(posedge clk) disable iff (rst)
    done && result.cell_alive |-> result.ack_kind == OP_READ)
    else $error("live cell reported for an operation other than read");

endmodule

bind life_automaton_torus lat_check u_check (.*);

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import lat_pkg::*;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;

  logic     clk;
  logic     rst;
  logic     start;
  lat_in_t  cmd;
  logic     busy;
  logic     done;
  lat_out_t result;

  bit       life [GRID_H][GRID_W];
  lat_out_t pending_acks [$];
  int       mismatches = 0;
  int       items_sent = 0;
  bit       no_idle = 1'b0;

  life_automaton_torus DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void evolve_grid();
    bit nxt [GRID_H][GRID_W];
    int n;
    for (int y = 0; y < GRID_H; y++) begin
      for (int x = 0; x < GRID_W; x++) begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if (dx != 0 || dy != 0) begin
              n += life[(y + dy + GRID_H) % GRID_H][(x + dx + GRID_W) % GRID_W];
            end
          end
        end
        nxt[y][x] = life[y][x] ? (n == 2 || n == 3) : (n == 3);
      end
    end
    life = nxt;
  endfunction

  function automatic lat_out_t apply_command(lat_in_t c);
    lat_out_t r;
    bit on_grid;
    on_grid = (c.col < GRID_W) && (c.row < GRID_H);
    r.cell_alive = 1'b0;
    r.ack_kind = c.op;
    case (lat_op_t'(c.op))
      OP_WRITE: begin
        if (on_grid) life[c.row][c.col] = c.alive_in;
      end
      OP_READ: begin
        if (on_grid) r.cell_alive = life[c.row][c.col];
      end
      OP_ADVANCE: begin
        evolve_grid();
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic lat_in_t mk_cmd(lat_op_t op, logic [5:0] col, logic [5:0] row,
                                     logic alive);
    lat_in_t c;
    c.op = op;
    c.col = col;
    c.row = row;
    c.alive_in = alive;
    return c;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [5:0] pick_coord();
    if ($urandom_range(0, 9) < 4) begin
      return $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'(62 + $urandom_range(0, 1));
    end
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic issue_cmd(input lat_in_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_acks.push_back(apply_command(c));
    items_sent++;
  endtask

  always @(posedge clk) begin
    lat_out_t want;
    if (!rst && done) begin
      if (pending_acks.size() == 0) begin
        $error("result beat with no command outstanding: cell_alive=%0b ack_kind=%0d",
               result.cell_alive, result.ack_kind);
        mismatches++;
      end else begin
        want = pending_acks.pop_front();
        if (result.cell_alive !== want.cell_alive) begin
          $error("cell_alive: expected %0b, got %0b", want.cell_alive, result.cell_alive);
          mismatches++;
        end
        if (result.ack_kind !== want.ack_kind) begin
          $error("ack_kind: expected %0d, got %0d", want.ack_kind, result.ack_kind);
          mismatches++;
        end
      end
    end
  end

  task automatic check_cleared_after_reset();
    issue_cmd(mk_cmd(OP_READ, 6'd0, 6'd0, 1'b1));
    issue_cmd(mk_cmd(OP_READ, 6'd63, 6'd63, 1'b0));
  endtask

  task automatic check_unused_op();
    issue_cmd(mk_cmd(OP_NONE, 6'd0, 6'd0, 1'b1));
    issue_cmd(mk_cmd(OP_READ, 6'd0, 6'd0, 1'b1));
  endtask

  task automatic check_blinker_wraps();
    issue_cmd(mk_cmd(OP_WRITE, 6'd63, 6'd63, 1'b1));
    issue_cmd(mk_cmd(OP_WRITE, 6'd0, 6'd63, 1'b1));
    issue_cmd(mk_cmd(OP_WRITE, 6'd1, 6'd63, 1'b1));
    issue_cmd(mk_cmd(OP_ADVANCE, 6'd63, 6'd63, 1'b1));
    issue_cmd(mk_cmd(OP_READ, 6'd0, 6'd62, 1'b0));
    issue_cmd(mk_cmd(OP_READ, 6'd0, 6'd0, 1'b0));
    issue_cmd(mk_cmd(OP_READ, 6'd63, 6'd63, 1'b0));
    issue_cmd(mk_cmd(OP_ADVANCE, 6'd21, 6'd42, 1'b0));
    issue_cmd(mk_cmd(OP_READ, 6'd63, 6'd63, 1'b0));
    issue_cmd(mk_cmd(OP_READ, 6'd0, 6'd0, 1'b0));
  endtask

  task automatic check_write_read_edges();
    issue_cmd(mk_cmd(OP_WRITE, 6'd63, 6'd0, 1'b1));
    issue_cmd(mk_cmd(OP_READ, 6'd63, 6'd0, 1'b0));
    issue_cmd(mk_cmd(OP_WRITE, 6'd63, 6'd0, 1'b0));
    issue_cmd(mk_cmd(OP_READ, 6'd63, 6'd0, 1'b1));
  endtask

  task automatic run_colony();
    logic [5:0] cx;
    logic [5:0] cy;
    int writes;
    int steps;
    int reads;
    cx = pick_coord();
    cy = pick_coord();
    no_idle = ($urandom_range(0, 3) == 0);
    writes = $urandom_range(4, 9);
    steps = $urandom_range(1, 3);
    reads = $urandom_range(4, 7);
    repeat (writes) begin
      issue_cmd(mk_cmd(OP_WRITE, cx + 6'($urandom_range(0, 3)), cy + 6'($urandom_range(0, 3)),
                       $urandom_range(0, 99) < 85));
    end
    repeat (steps) begin
      issue_cmd(mk_cmd(OP_ADVANCE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1))));
    end
    repeat (reads) begin
      issue_cmd(mk_cmd(OP_READ, cx + 6'($urandom_range(0, 5)) - 6'd1,
                       cy + 6'($urandom_range(0, 5)) - 6'd1, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_noise();
    no_idle = 1'b0;
    repeat ($urandom_range(1, 3)) begin
      issue_cmd(mk_cmd(lat_op_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                       6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic run_random_traffic(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 6) run_colony();
      else run_noise();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    check_cleared_after_reset();
    check_unused_op();
    check_blinker_wraps();
    check_write_read_edges();
    run_random_traffic(120);
    start <= 1'b0;
    while (pending_acks.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
